// File: rtl/core/brpc_pkg.sv
// Shared types and constants for the binary relation property checker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package brpc_pkg;

  localparam int unsigned MaxElements = 16;
  localparam int unsigned KeyBits     = 32;

  typedef enum logic [1:0] {
    CmdClear   = 2'd0,
    CmdAdd     = 2'd1,
    CmdConnect = 2'd2,
    CmdUnused  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatMissing = 2'd1,
    StatFull    = 2'd2,
    StatLocked  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StSweep,
    StPush
  } state_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [KeyBits-1:0] key_a;
    logic [KeyBits-1:0] key_b;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic       is_reflexive;
    logic       is_symmetric;
    logic       is_antisymmetric;
    logic       is_transitive;
    logic       is_equivalence;
    logic       is_partial_order;
    logic [4:0] domain_count;
  } out_beat_t;

  typedef struct packed {
    logic clr;
    logic ins;
    logic conn;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/brpc_cell.sv
// One domain slot: a sorted key and its relation row.
// Depends on brpc_pkg.
`default_nettype none

module brpc_cell #(
  parameter int unsigned MaxElements = brpc_pkg::MaxElements
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire brpc_pkg::cell_ctl_t             ctl_i,
  input  wire logic                            live_i,
  input  wire logic                            at_end_i,
  input  wire logic [brpc_pkg::KeyBits-1:0]    key_a_i,
  input  wire logic [brpc_pkg::KeyBits-1:0]    key_b_i,
  input  wire logic [brpc_pkg::KeyBits-1:0]    prev_key_i,
  input  wire logic                            prev_gt_i,
  input  wire logic [MaxElements-1:0]          conn_mask_i,
  input  wire logic [$clog2(MaxElements)-1:0]  idx_i,
  input  wire logic                            row_sel_i,
  output logic [brpc_pkg::KeyBits-1:0]         key_o,
  output logic                                 gt_o,
  output logic                                 match_a_o,
  output logic                                 match_b_o,
  output logic                                 col_o,
  output logic [MaxElements-1:0]               row_o,
  output logic [MaxElements-1:0]               reach_o
);
  import brpc_pkg::*;

  logic [KeyBits-1:0]     key_q, key_d;
  logic [MaxElements-1:0] row_q, row_d;

  assign gt_o      = live_i && (key_q > key_a_i);
  assign match_a_o = live_i && (key_q == key_a_i);
  assign match_b_o = live_i && (key_q == key_b_i);
  assign col_o     = row_q[idx_i];
  assign row_o     = row_q;
  assign reach_o   = row_sel_i ? row_q : '0;
  assign key_o     = key_q;

  always_comb begin
    key_d = key_q;
    if (ctl_i.ins && (gt_o || at_end_i)) begin
      key_d = prev_gt_i ? prev_key_i : key_a_i;
    end
  end

  always_comb begin
    row_d = row_q;
    if (ctl_i.clr) begin
      row_d = '0;
    end else if (ctl_i.conn && match_a_o) begin
      row_d = row_q | conn_mask_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/binary_relation_property_checker.sv
// Top level: command sequencer, chain of key/row cells, property sweep.
// Depends on brpc_pkg and brpc_cell.
`default_nettype none

// Keeps a sorted set of up to MaxElements keys in a chain of cells, one key and
// one relation row per cell, and reports the relation's properties after each
// command. Each item is captured, then every cell compares the keys and shifts
// or updates in place, then the property sweep reads one relation row per cycle,
// and then the result register is loaded once the previous result is taken.
// A new item is taken while the previous result still waits.

module binary_relation_property_checker #(
  parameter int unsigned MaxElements = brpc_pkg::MaxElements
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire brpc_pkg::in_beat_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output brpc_pkg::out_beat_t      out_data_o
);
  import brpc_pkg::*;

  localparam int unsigned N  = MaxElements;
  localparam int unsigned IW = $clog2(N);
  localparam int unsigned CW = $clog2(N + 1);

  state_e            state_q, state_d;
  in_beat_t          item_q;
  logic [CW-1:0]     count_q, count_d;
  logic              locked_q, locked_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [1:0]        status_q, status_d;
  logic              refl_q, sym_q, anti_q, trans_q;
  logic              refl_d, sym_d, anti_d, trans_d;
  logic              out_valid_q;
  out_beat_t         out_q;

  logic              exec, sweep, push_go, sweep_last, full;
  cell_ctl_t         ctl;
  logic              found_a, found_b;

  logic [KeyBits-1:0] key_w [N];
  logic [N-1:0]       gt_w, ma_w, mb_w, col_w, live, sel;
  logic [N-1:0]       row_w [N];
  logic [N-1:0]       reach_w [N];
  logic [N-1:0]       cur_row, reach, row_sel;

  assign found_a    = |ma_w;
  assign found_b    = |mb_w;
  assign full       = (count_q == CW'(N));
  assign sweep_last = (count_q == '0) || ((CW'(idx_q) + CW'(1)) == count_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StExec;
      StExec:  state_d = StSweep;
      StSweep: if (sweep_last) state_d = StPush;
      StPush:  if (!out_valid_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready_o = 1'b0;
    exec       = 1'b0;
    sweep      = 1'b0;
    push_go    = 1'b0;
    case (state_q)
      StIdle:  in_ready_o = 1'b1;
      StExec:  exec       = 1'b1;
      StSweep: sweep      = 1'b1;
      StPush:  push_go    = !out_valid_q || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_comb begin
    ctl      = '0;
    status_d = status_q;
    count_d  = count_q;
    locked_d = locked_q;
    if (exec) begin
      status_d = StatOk;
      case (item_q.cmd)
        CmdClear: begin
          ctl.clr  = 1'b1;
          count_d  = '0;
          locked_d = 1'b0;
        end
        CmdAdd: begin
          if (locked_q) begin
            status_d = StatLocked;
          end else if (!found_a) begin
            if (full) begin
              status_d = StatFull;
            end else begin
              ctl.ins = 1'b1;
              count_d = count_q + CW'(1);
            end
          end
        end
        CmdConnect: begin
          if (found_a && found_b) begin
            ctl.conn = 1'b1;
            locked_d = 1'b1;
          end else begin
            status_d = StatMissing;
          end
        end
        default: status_d = StatOk;
      endcase
    end
  end

  always_comb begin
    cur_row = '0;
    reach   = '0;
    for (int j = 0; j < N; j++) begin
      if (sel[j]) cur_row = cur_row | row_w[j];
      reach = reach | reach_w[j];
    end
  end

  assign row_sel = cur_row & live;

  always_comb begin
    refl_d  = refl_q;
    sym_d   = sym_q;
    anti_d  = anti_q;
    trans_d = trans_q;
    idx_d   = idx_q;
    if (exec) begin
      refl_d  = 1'b1;
      sym_d   = 1'b1;
      anti_d  = 1'b1;
      trans_d = 1'b1;
      idx_d   = '0;
    end else if (sweep && (count_q != '0)) begin
      refl_d  = refl_q && cur_row[idx_q];
      sym_d   = sym_q && (((cur_row ^ col_w) & live) == '0);
      anti_d  = anti_q && ((cur_row & col_w & live & ~sel) == '0);
      trans_d = trans_q && ((reach & live & ~cur_row) == '0);
      idx_d   = idx_q + IW'(1);
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_cell
    assign live[j] = (CW'(j) < count_q);
    assign sel[j]  = (idx_q == IW'(j));

    brpc_cell #(
      .MaxElements (MaxElements)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .live_i      (live[j]),
      .at_end_i    (count_q == CW'(j)),
      .key_a_i     (item_q.key_a),
      .key_b_i     (item_q.key_b),
      .prev_key_i  ((j == 0) ? '0 : key_w[(j == 0) ? 0 : j - 1]),
      .prev_gt_i   ((j == 0) ? 1'b0 : gt_w[(j == 0) ? 0 : j - 1]),
      .conn_mask_i (mb_w),
      .idx_i       (idx_q),
      .row_sel_i   (row_sel[j]),
      .key_o       (key_w[j]),
      .gt_o        (gt_w[j]),
      .match_a_o   (ma_w[j]),
      .match_b_o   (mb_w[j]),
      .col_o       (col_w[j]),
      .row_o       (row_w[j]),
      .reach_o     (reach_w[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      locked_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      locked_q <= locked_d;
      idx_q    <= idx_d;
      if (push_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    status_q <= status_d;
    refl_q   <= refl_d;
    sym_q    <= sym_d;
    anti_q   <= anti_d;
    trans_q  <= trans_d;
    if (push_go) begin
      out_q.status           <= status_q;
      out_q.is_reflexive     <= refl_q;
      out_q.is_symmetric     <= sym_q;
      out_q.is_antisymmetric <= anti_q;
      out_q.is_transitive    <= trans_q;
      out_q.is_equivalence   <= refl_q && sym_q && trans_q;
      out_q.is_partial_order <= refl_q && anti_q && trans_q;
      out_q.domain_count     <= 5'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/core/brpc_checker.sv
// Port-level assertions for the binary relation property checker, and the
// bind that attaches them. Depends on brpc_pkg.
`default_nettype none

module brpc_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire brpc_pkg::out_beat_t out_data_o
);
  import brpc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  a_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input beat taken while busy");

  a_equiv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.is_equivalence == (out_data_o.is_reflexive &&
      out_data_o.is_symmetric && out_data_o.is_transitive))
    else $error("equivalence flag inconsistent");

  a_porder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.is_partial_order == (out_data_o.is_reflexive &&
      out_data_o.is_antisymmetric && out_data_o.is_transitive))
    else $error("partial order flag inconsistent");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.domain_count == 5'd0) |->
      out_data_o.is_reflexive && out_data_o.is_symmetric &&
      out_data_o.is_antisymmetric && out_data_o.is_transitive)
    else $error("empty domain must report all flags set");

endmodule

bind binary_relation_property_checker brpc_checker u_brpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// File: bench/brpc_scoreboard.sv
// Checker for the binary relation property checker: watches both channels,
// predicts each result beat from accepted input beats and compares them.
// Depends on brpc_pkg.
`timescale 1ns / 1ps

module brpc_scoreboard (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire brpc_pkg::in_beat_t  in_data_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire brpc_pkg::out_beat_t out_data_i,
  output int                       errors_o,
  output int                       pending_o
);
  import brpc_pkg::*;

  logic [KeyBits-1:0]     keys [MaxElements];
  logic [MaxElements-1:0] rows [MaxElements];
  int                     nkeys;
  logic                   locked;
  out_beat_t              expected_q [$];

  function automatic int find_key(logic [KeyBits-1:0] k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = nkeys;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (keys[mid] == k) return mid;
      if (keys[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    return -1;
  endfunction

  function automatic out_beat_t apply_command(in_beat_t b);
    out_beat_t r;
    int x;
    int y;
    int i;
    bit refl;
    bit sym;
    bit anti;
    bit trans;
    logic [MaxElements-1:0] live;
    r = '0;
    r.status = StatOk;
    case (b.cmd)
      CmdClear: begin
        nkeys = 0;
        locked = 1'b0;
        foreach (rows[k]) rows[k] = '0;
      end
      CmdAdd: begin
        if (locked) r.status = StatLocked;
        else if (find_key(b.key_a) >= 0) r.status = StatOk;
        else if (nkeys >= MaxElements) r.status = StatFull;
        else begin
          i = nkeys;
          while (i > 0 && keys[i-1] > b.key_a) begin
            keys[i] = keys[i-1];
            i--;
          end
          keys[i] = b.key_a;
          nkeys++;
        end
      end
      CmdConnect: begin
        x = find_key(b.key_a);
        y = find_key(b.key_b);
        if (x < 0 || y < 0) r.status = StatMissing;
        else begin
          rows[x][y] = 1'b1;
          locked = 1'b1;
        end
      end
      default: ;
    endcase
    refl = 1; sym = 1; anti = 1; trans = 1;
    live = '0;
    for (i = 0; i < nkeys; i++) live[i] = 1'b1;
    for (i = 0; i < nkeys; i++) begin
      if (!rows[i][i]) refl = 0;
      for (int j = 0; j < nkeys; j++) begin
        if (rows[i][j] != rows[j][i]) sym = 0;
        if (i != j && rows[i][j] && rows[j][i]) anti = 0;
        if (rows[i][j] && ((rows[j] & live & ~(rows[i] & live)) != '0)) trans = 0;
      end
    end
    r.is_reflexive     = refl;
    r.is_symmetric     = sym;
    r.is_antisymmetric = anti;
    r.is_transitive    = trans;
    r.is_equivalence   = refl && sym && trans;
    r.is_partial_order = refl && anti && trans;
    r.domain_count     = nkeys[4:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t e;
    if (!rst_ni) begin
      nkeys    = 0;
      locked   = 1'b0;
      foreach (rows[k]) rows[k] = '0;
      expected_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: %h", out_data_i);
          errors_o <= errors_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== out_data_i) begin
            errors_o <= errors_o + 1;
            if (e.status !== out_data_i.status)
              $error("status exp %0d got %0d", e.status, out_data_i.status);
            if (e.is_reflexive !== out_data_i.is_reflexive)
              $error("is_reflexive exp %0d got %0d", e.is_reflexive,
                     out_data_i.is_reflexive);
            if (e.is_symmetric !== out_data_i.is_symmetric)
              $error("is_symmetric exp %0d got %0d", e.is_symmetric,
                     out_data_i.is_symmetric);
            if (e.is_antisymmetric !== out_data_i.is_antisymmetric)
              $error("is_antisymmetric exp %0d got %0d", e.is_antisymmetric,
                     out_data_i.is_antisymmetric);
            if (e.is_transitive !== out_data_i.is_transitive)
              $error("is_transitive exp %0d got %0d", e.is_transitive,
                     out_data_i.is_transitive);
            if (e.is_equivalence !== out_data_i.is_equivalence)
              $error("is_equivalence exp %0d got %0d", e.is_equivalence,
                     out_data_i.is_equivalence);
            if (e.is_partial_order !== out_data_i.is_partial_order)
              $error("is_partial_order exp %0d got %0d", e.is_partial_order,
                     out_data_i.is_partial_order);
            if (e.domain_count !== out_data_i.domain_count)
              $error("domain_count exp %0d got %0d", e.domain_count,
                     out_data_i.domain_count);
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_q = {expected_q, apply_command(in_data_i)};
      pending_o <= expected_q.size();
    end
  end
endmodule

// File: bench/tb_binary_relation_property_checker.sv
// Testbench top: drives command beats into the relation checker with random
// gaps and output stalls; verdict comes from brpc_scoreboard. Depends on brpc_pkg.
`timescale 1ns / 1ps

module tb_binary_relation_property_checker;
  import brpc_pkg::*;

  localparam int CycleLimit = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;
  int        errors;
  int        pending;
  int        cycles = 0;
  logic [KeyBits-1:0] pool [MaxElements];

  always #2 clk = ~clk;

  binary_relation_property_checker dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  brpc_scoreboard u_scoreboard (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .errors_o(errors), .pending_o(pending)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL binary_relation_property_checker");
      $finish;
    end
  end

  // output stalls; some stretches with ready held high
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 3) == 0) begin
        n = gap_len();
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 80)) @(posedge clk);
    end
  end

  task automatic send(logic [1:0] cmd, logic [KeyBits-1:0] a, logic [KeyBits-1:0] b,
                      bit use_gap);
    int n;
    n = use_gap ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{cmd: cmd, key_a: a, key_b: b};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_in();
    in_valid <= 1'b0;
  endtask

  function automatic logic [KeyBits-1:0] any_key();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int npool;
    int sent;
    int nrel;
    bit quiet;
    logic [KeyBits-1:0] ka;
    logic [KeyBits-1:0] kb;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty domain, extremes, duplicate, missing, full, locked, unused cmd
    send(CmdClear, '0, '0, 0);
    send(CmdConnect, '0, '0, 0);
    send(CmdUnused, '1, '1, 0);
    send(CmdAdd, '1, '0, 0);
    send(CmdAdd, '0, '1, 0);
    send(CmdAdd, '1, '0, 0);
    send(CmdConnect, '0, 32'h5, 0);
    send(CmdConnect, '0, '1, 0);
    send(CmdAdd, 32'h7, '0, 0);
    send(CmdConnect, '1, '0, 1);
    send(CmdConnect, '0, '0, 0);
    send(CmdConnect, '1, '1, 0);
    send(CmdClear, '1, '1, 0);
    for (int i = 0; i < 17; i++) send(CmdAdd, 32'hAAAA_5555 ^ (i * 32'h1111_0001), '0, 1);
    send(CmdClear, '0, '0, 0);

    sent = 0;
    while (sent < 1150) begin
      // well-formed episode: clear, build domain, connect pairs, few noise beats
      npool = $urandom_range(0, 9) == 0 ? $urandom_range(14, 18) : $urandom_range(1, 6);
      quiet = $urandom_range(0, 4) == 0;
      send(CmdClear, $urandom, $urandom, !quiet);
      sent++;
      for (int i = 0; i < npool; i++) begin
        ka = any_key();
        if (i < MaxElements) pool[i] = ka;
        send(CmdAdd, ka, $urandom, !quiet);
        sent++;
      end
      if (npool > MaxElements) npool = MaxElements;
      nrel = $urandom_range(0, 3 * npool + 2);
      for (int i = 0; i < nrel; i++) begin
        ka = pool[$urandom_range(0, npool - 1)];
        kb = pool[$urandom_range(0, npool - 1)];
        case ($urandom_range(0, 11))
          0: send(CmdAdd, any_key(), $urandom, !quiet);
          1: send(CmdUnused, $urandom, $urandom, !quiet);
          2: send(CmdConnect, any_key(), kb, !quiet);
          3: send(CmdConnect, ka, ka, !quiet);
          default: send(CmdConnect, ka, kb, !quiet);
        endcase
        sent++;
      end
    end
    idle_in();

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("PASS binary_relation_property_checker");
    else $display("FAIL binary_relation_property_checker");
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/brpc_pkg.sv
rtl/core/brpc_cell.sv
rtl/core/binary_relation_property_checker.sv
rtl/core/brpc_checker.sv
bench/brpc_scoreboard.sv
bench/tb_binary_relation_property_checker.sv
